FILE: hw/rtl/aops_pkg.sv
// shared types and constants for the aging obstacle point store
// no dependencies
`timescale 1ns / 1ps
package aops_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] REG_Z_MIN    = 3'd0;
  localparam logic [2:0] REG_Z_MAX    = 3'd1;
  localparam logic [2:0] REG_LIFETIME = 3'd2;
  localparam logic [2:0] REG_LIMIT    = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;

  localparam int unsigned LIFE_MIN  = 100;
  localparam int unsigned LIMIT_MIN = 100;

  localparam int unsigned COORD_BITS = 24;

  // squared distance width: two difference magnitudes squared and summed
  localparam int unsigned D2_BITS = 2 * (COORD_BITS + 2) + 1;
  localparam int unsigned ROOT_BITS = (D2_BITS + 1) / 2;

  typedef struct packed {
    logic       start;
    logic [D2_BITS-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] root;
  } sqrt_rsp_t;

endpackage

FILE: hw/rtl/aops_isqrt.sv
// iterative integer square root, one result bit per cycle
// depends on aops_pkg
`timescale 1ns / 1ps
module aops_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  aops_pkg::sqrt_req_t req,
  output aops_pkg::sqrt_rsp_t rsp
);

  localparam int unsigned VB = 2 * aops_pkg::ROOT_BITS;

  logic [VB-1:0] rem_r, rem_nxt;
  logic [VB-1:0] root_r, root_nxt;
  logic [VB-1:0] bit_r, bit_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [VB-1:0] trial;

  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = VB'(req.radicand);
      root_nxt = '0;
      bit_nxt  = {2'b01, {(VB-2){1'b0}}};
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[1:0] != 2'b00) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[aops_pkg::ROOT_BITS-1:0];

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("sqrt done held");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("sqrt busy at done");
  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (root_r[VB-1:aops_pkg::ROOT_BITS] == '0)) else $error("root too wide");

endmodule

FILE: hw/rtl/aging_obstacle_point_store_top.sv
// aging obstacle point store: circular point memory, compaction sweep, nearest scan
// depends on aops_pkg and aops_isqrt
//
//   port group | direction | handshake
//   in_*       | in        | in_valid / in_stall
//   out_*      | out       | out_valid / out_stall
//   cfg_*      | in        | apb write and read, always ready
//
// each command sweeps every stored point once (one memory access per cycle) to prune,
// then a query sweeps again to find the nearest squared distance, then takes the
// square root of that distance if a point at or beyond the radius was found
// reset clears control only; the point memory needs no clearing
// a held result blocks the next transfer until out_stall drops
`timescale 1ns / 1ps
module aging_obstacle_point_store_top #(
  parameter int CAPACITY   = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_command,
  input  logic signed [aops_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [aops_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [aops_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic [31:0]            in_now_ms,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [23:0]            out_min_distance,
  output logic                   out_has_recent,
  output logic [10:0]            out_point_count,
  output logic                   out_accepted,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [4:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int COORD_BITS = aops_pkg::COORD_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int DB = COORD_BITS + 2;
  localparam int D2 = 2 * DB + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PRUNE = 7'b0000010,
    S_PWAIT = 7'b0000100,
    S_ACT   = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [23:0] z_min_r, z_max_r;
  logic [19:0] life_r;
  logic [10:0] limit_r;
  logic [22:0] radius_r;
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_min_r  <= -24'sd8388608;
      z_max_r  <= 24'sd8388607;
      life_r   <= 20'd1000;
      limit_r  <= 11'd1024;
      radius_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        aops_pkg::REG_Z_MIN:    z_min_r  <= cfg_pwdata[23:0];
        aops_pkg::REG_Z_MAX:    z_max_r  <= cfg_pwdata[23:0];
        aops_pkg::REG_LIFETIME: life_r   <= cfg_pwdata[19:0];
        aops_pkg::REG_LIMIT:    limit_r  <= cfg_pwdata[10:0];
        aops_pkg::REG_RADIUS:   radius_r <= cfg_pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      aops_pkg::REG_Z_MIN:    cfg_prdata = {{8{z_min_r[23]}}, z_min_r};
      aops_pkg::REG_Z_MAX:    cfg_prdata = {{8{z_max_r[23]}}, z_max_r};
      aops_pkg::REG_LIFETIME: cfg_prdata = {12'd0, life_r};
      aops_pkg::REG_LIMIT:    cfg_prdata = {21'd0, limit_r};
      aops_pkg::REG_RADIUS:   cfg_prdata = {9'd0, radius_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // point memory, one entry of x, y and stamp
  localparam int EW = 2 * COORD_BITS + 32;
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // command latch
  logic [1:0] cmd_r;
  logic signed [COORD_BITS-1:0] px_r, py_r, pz_r;
  logic [31:0] now_r;

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic [CW-1:0] k_r, k_nxt, w_r, w_nxt;
  logic          rv_r, rv_nxt;        // read data valid
  logic          recent_r, recent_nxt, acc_r, acc_nxt;
  logic [D2-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [23:0]   dist_r, dist_nxt;

  logic [19:0] life_eff;
  logic [CW-1:0] limit_eff;
  assign life_eff = (life_r < 20'(aops_pkg::LIFE_MIN)) ? 20'(aops_pkg::LIFE_MIN) : life_r;
  always_comb begin
    if (limit_r < 11'(aops_pkg::LIMIT_MIN)) limit_eff = CW'(aops_pkg::LIMIT_MIN);
    else if (32'(limit_r) > 32'(CAPACITY)) limit_eff = CAP_C;
    else limit_eff = CW'(limit_r);
  end

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
    logic [CW-1:0] s;
    s = CW'(base) + k;
    if (s >= CAP_C) s = s - CAP_C;
    return s[AW-1:0];
  endfunction

  // unpack read data
  logic signed [COORD_BITS-1:0] rx, ry;
  logic [31:0] rt;
  assign rx = rd_data_r[EW-1 -: COORD_BITS];
  assign ry = rd_data_r[EW-1-COORD_BITS -: COORD_BITS];
  assign rt = rd_data_r[31:0];

  logic keep;
  logic [31:0] age;
  assign age = now_r - rt;
  assign keep = age <= {12'd0, life_eff};

  // squared distance of the read point, from absolute differences
  logic signed [DB-1:0] dx, dy;
  logic [DB-1:0] ax, ay;
  logic [2*DB-1:0] sx, sy;
  logic [D2-1:0] d2;
  logic [47:0] r2;
  assign dx = DB'(rx) - DB'(px_r);
  assign dy = DB'(ry) - DB'(py_r);
  assign ax = dx[DB-1] ? DB'(-dx) : DB'(dx);
  assign ay = dy[DB-1] ? DB'(-dy) : DB'(dy);
  assign sx = ax * ax;
  assign sy = ay * ay;
  assign d2 = D2'(sx) + D2'(sy);
  assign r2 = radius_r * radius_r;

  // oldest entries to evict so an insert stays within the limit; applied in act
  logic [CW-1:0] evict_n;
  assign evict_n = (total_r >= limit_eff) ? (total_r - limit_eff + CW'(1)) : '0;

  aops_pkg::sqrt_req_t sq_req;
  aops_pkg::sqrt_rsp_t sq_rsp;
  aops_isqrt u_isqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  logic in_xfer, out_xfer, z_ok;
  assign in_stall = state_r != S_IDLE;
  assign in_xfer  = in_valid && !in_stall;
  assign out_valid = state_r == S_OUT;
  assign out_xfer = out_valid && !out_stall;
  assign z_ok = (pz_r >= COORD_BITS'(z_min_r)) && (pz_r <= COORD_BITS'(z_max_r))
                && ($signed(z_min_r) <= $signed(z_max_r));

  always_comb begin
    state_nxt  = state_r;
    oldest_nxt = oldest_r;
    total_nxt  = total_r;
    k_nxt = k_r; w_nxt = w_r;
    rv_nxt = 1'b0;
    recent_nxt = recent_r; acc_nxt = acc_r;
    best_nxt = best_r; found_nxt = found_r; dist_nxt = dist_r;
    rd_addr = slot(oldest_r, k_r);
    wr_en = 1'b0; wr_addr = slot(oldest_r, w_r);
    wr_data = rd_data_r;
    sq_req.start = 1'b0;
    sq_req.radicand = aops_pkg::D2_BITS'(best_r);
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_PRUNE;
          k_nxt = '0; w_nxt = '0;
          acc_nxt = 1'b0; found_nxt = 1'b0; dist_nxt = '1;
        end
      end
      S_PRUNE: begin
        // issue reads, compact kept entries behind
        if (k_r < total_r) begin
          rv_nxt = 1'b1; k_nxt = k_r + CW'(1);
        end else if (!rv_r) begin
          state_nxt = S_PWAIT;
        end
        if (rv_r && keep) begin
          wr_en = 1'b1;
          w_nxt = w_r + CW'(1);
        end
      end
      S_PWAIT: begin
        total_nxt = w_r;
        recent_nxt = w_r != '0;
        state_nxt = S_ACT;
      end
      S_ACT: begin
        k_nxt = '0;
        case (cmd_r)
          aops_pkg::CMD_INSERT: begin
            if (z_ok) begin
              wr_en = 1'b1;
              oldest_nxt = slot(oldest_r, evict_n);
              wr_addr = slot(oldest_r, total_r);
              wr_data = {px_r, py_r, now_r};
              total_nxt = total_r - evict_n + CW'(1);
              acc_nxt = 1'b1;
            end
            state_nxt = S_OUT;
          end
          aops_pkg::CMD_QUERY: state_nxt = S_SCAN;
          aops_pkg::CMD_CLEAR: begin
            total_nxt = '0; oldest_nxt = '0; state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_SCAN: begin
        if (k_r < total_r) begin
          rv_nxt = 1'b1; k_nxt = k_r + CW'(1);
        end else if (!rv_r) begin
          if (found_r) begin
            sq_req.start = 1'b1;
            state_nxt = S_SQRT;
          end else begin
            state_nxt = S_OUT;
          end
        end
        if (rv_r && (d2 >= D2'(r2)) && (!found_r || d2 < best_r)) begin
          best_nxt = d2; found_nxt = 1'b1;
        end
      end
      S_SQRT: begin
        if (sq_rsp.done) begin
          dist_nxt = (sq_rsp.root >= aops_pkg::ROOT_BITS'(24'hFFFFFF)) ? 24'hFFFFFF
                     : sq_rsp.root[23:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      oldest_r <= '0;
      total_r  <= '0;
      rv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      total_r  <= total_nxt;
      rv_r     <= rv_nxt;
    end
    k_r <= k_nxt; w_r <= w_nxt;
    recent_r <= recent_nxt; acc_r <= acc_nxt;
    best_r <= best_nxt; found_r <= found_nxt; dist_r <= dist_nxt;
    if (in_xfer) begin
      cmd_r <= in_command; px_r <= in_pos_x; py_r <= in_pos_y;
      pz_r <= in_pos_z; now_r <= in_now_ms;
    end
  end

  assign out_min_distance = dist_r;
  assign out_has_recent   = recent_r;
  assign out_point_count  = 11'(total_r);
  assign out_accepted     = acc_r;

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CAP_C) else $error("store over capacity");
  a_write_behind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRUNE |-> w_r <= k_r) else $error("compaction overtook read");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(dist_r)) else $error("result lost");
  a_acc_insert: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && acc_r |-> cmd_r == aops_pkg::CMD_INSERT) else $error("accept flag");

endmodule
